>>> sv/pcfp_pkg.sv
`timescale 1ns / 1ps

package pcfp_pkg;

  localparam logic [7:0] HdrByte  = 8'hFF;
  localparam logic [7:0] CmdHome  = 8'hFA;
  localparam logic [7:0] CmdRepX  = 8'hFB;
  localparam logic [7:0] CmdMove  = 8'hFC;
  localparam logic [7:0] CmdRepY  = 8'hFD;
  localparam logic [7:0] TermByte = 8'hFE;

  localparam logic [7:0] DeviceIdReset = 8'h30;

  localparam int unsigned ValueW  = 15;
  localparam int unsigned CountW  = 20;
  localparam int unsigned ResultW = 5 + 2 * CountW;
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

  // Fields from the lowest bit up: nak, home, report_x, report_y,
  // target_valid, target_x, target_y.
  typedef struct packed {
    logic [CountW-1:0] target_y;
    logic [CountW-1:0] target_x;
    logic              target_valid;
    logic              report_y_cmd;
    logic              report_x_cmd;
    logic              home_cmd;
    logic              nak;
  } pcfp_result_t;

endpackage

>>> sv/pcfp_scale.sv
`timescale 1ns / 1ps

module pcfp_scale (
  input  logic [pcfp_pkg::ValueW-1:0] value_i,
  output logic [pcfp_pkg::CountW-1:0] counts_o
);
  import pcfp_pkg::*;

  // value * 512 / 15 = value * 34 + (2 * value) / 15. The remainder term
  // uses a reciprocal of 15 scaled by 2^19, exact for a 16-bit dividend
  // below 74898.
  localparam logic [15:0] Recip15 = 16'h8889;

  logic [15:0]       twice;
  logic [31:0]       prod;
  logic [12:0]       frac;
  logic [CountW-1:0] whole;

  assign twice = {value_i, 1'b0};
  assign prod  = twice * Recip15;
  assign frac  = prod[31:19];
  assign whole = {value_i, 5'd0} + {4'd0, value_i, 1'b0};

  assign counts_o = whole + {7'd0, frac};

endmodule

>>> sv/pcfp_parser.sv
`timescale 1ns / 1ps

module pcfp_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_data_i,
  input  logic                   accept_i,
  input  logic [7:0]             rx_byte_i,
  output pcfp_pkg::pcfp_result_t result_o
);
  import pcfp_pkg::*;

  localparam logic [3:0] StHdr0  = 4'd0;
  localparam logic [3:0] StHdr1  = 4'd1;
  localparam logic [3:0] StAddr  = 4'd2;
  localparam logic [3:0] StCmd   = 4'd3;
  localparam logic [3:0] StXHigh = 4'd4;
  localparam logic [3:0] StXLow  = 4'd5;
  localparam logic [3:0] StYHigh = 4'd6;
  localparam logic [3:0] StYLow  = 4'd7;
  localparam logic [3:0] StTerm  = 4'd8;

  logic [3:0]        step_q, step_d;
  logic [7:0]        device_id_q;
  logic [7:0]        x_high_q, x_high_d, y_high_q, y_high_d;
  logic [ValueW-1:0] x_value_q, x_value_d, y_value_q, y_value_d;
  logic [ValueW-1:0] low_value;
  logic [CountW-1:0] x_counts, y_counts;

  pcfp_scale u_scale_x (.value_i(x_value_q), .counts_o(x_counts));
  pcfp_scale u_scale_y (.value_i(y_value_q), .counts_o(y_counts));

  // High byte taken in the previous step times 100, plus the low byte.
  always_comb begin
    logic [7:0] hi;
    hi = (step_q == StXLow) ? x_high_q : y_high_q;
    low_value = {1'b0, hi, 6'd0} + {2'd0, hi, 5'd0} + {5'd0, hi, 2'd0}
              + {7'd0, rx_byte_i};
  end

  always_comb begin
    step_d    = step_q;
    x_high_d  = x_high_q;
    y_high_d  = y_high_q;
    x_value_d = x_value_q;
    y_value_d = y_value_q;
    result_o  = '0;
    unique case (step_q)
      StHdr1, StHdr0: begin
        if (rx_byte_i == HdrByte) begin
          step_d = step_q + 4'd1;
        end else begin
          result_o.nak = 1'b1;
          step_d = StHdr0;
        end
      end
      StAddr: begin
        if (rx_byte_i == device_id_q) begin
          step_d = StCmd;
        end else begin
          result_o.nak = 1'b1;
          step_d = StHdr0;
        end
      end
      StCmd: begin
        step_d = StHdr0;
        priority if (rx_byte_i == CmdHome) begin
          result_o.home_cmd = 1'b1;
        end else if (rx_byte_i == CmdRepX) begin
          result_o.report_x_cmd = 1'b1;
        end else if (rx_byte_i == CmdRepY) begin
          result_o.report_y_cmd = 1'b1;
        end else if (rx_byte_i == CmdMove) begin
          step_d = StXHigh;
        end else begin
          result_o.nak = 1'b1;
        end
      end
      StXHigh: begin
        x_high_d = rx_byte_i;
        step_d   = StXLow;
      end
      StXLow: begin
        x_value_d = low_value;
        step_d    = StYHigh;
      end
      StYHigh: begin
        y_high_d = rx_byte_i;
        step_d   = StYLow;
      end
      StYLow: begin
        y_value_d = low_value;
        step_d    = StTerm;
      end
      StTerm: begin
        if (rx_byte_i == TermByte) begin
          result_o.target_valid = 1'b1;
          result_o.target_x     = x_counts;
          result_o.target_y     = y_counts;
          step_d = StHdr0;
        end
      end
      default: begin
        // Codes past the terminator wait cannot arise; treat as first header.
        if (rx_byte_i == HdrByte) begin
          step_d = StHdr1;
        end else begin
          result_o.nak = 1'b1;
          step_d = StHdr0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= StHdr0;
      x_high_q  <= '0;
      y_high_q  <= '0;
      x_value_q <= '0;
      y_value_q <= '0;
    end else if (accept_i) begin
      step_q    <= step_d;
      x_high_q  <= x_high_d;
      y_high_q  <= y_high_d;
      x_value_q <= x_value_d;
      y_value_q <= y_value_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= DeviceIdReset;
    end else if (cfg_we_i) begin
      device_id_q <= cfg_data_i;
    end
  end

endmodule

>>> sv/position_command_frame_parser.sv
`timescale 1ns / 1ps

// Position command frame parser.
// Input stream s_axis: one received serial byte per request in tdata[7:0].
// Output stream m_axis: exactly one result per input byte, carrying the
// nak, home, report-X and report-Y flags, target_valid and the two targets
// in encoder counts (zero unless target_valid is set).
// Configuration channel cfg: writes the device ID that the third frame
// byte must match; it is always ready and should be written while the
// block is idle.
// The result of an accepted byte is registered and is on m_axis in the next
// cycle. Throughput is one byte per cycle while the receiver takes each
// result, set by the single output register; a byte is taken in the same
// cycle that the waiting result is taken.
// When the receiver stalls, the result holds in the output register and
// s_axis_tready_o drops until it is taken.
// Reset clears the frame parser to the first header byte, clears the
// captured values and the output register, and sets the device ID to 0x30.
module position_command_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [7:0]                    cfg_data_i,     // device_id
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i, // rx_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // nak, home_cmd, report_x_cmd, report_y_cmd, target_valid,
  // target_x[19:0], target_y[19:0], zero padding
  output logic [pcfp_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import pcfp_pkg::*;

  pcfp_result_t result;
  pcfp_result_t out_q;
  logic         out_valid_q;
  logic         accept;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  pcfp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .rx_byte_i  (s_axis_tdata_i),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        out_q       <= result;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - ResultW)'(0), out_q};

endmodule

>>> sv/pcfp_checker.sv
`timescale 1ns / 1ps

module pcfp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [pcfp_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import pcfp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Every accepted byte shows up as a result in the following cycle.
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted byte gave no result");

  // A byte raises at most one event flag.
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot0(m_axis_tdata_o[4:0]))
    else $error("more than one event flag in a result");

  a_targets_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[4] |-> m_axis_tdata_o[ResultW-1:5] == '0)
    else $error("targets nonzero without target_valid");

endmodule

bind position_command_frame_parser pcfp_checker u_pcfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
